// ===== src/kot_pkg.sv =====
package kot_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int OUT_LEN_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SPACE   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_CSTAR   = 3'd3,
    MODE_IDENT   = 3'd4,
    MODE_NUMBER  = 3'd5,
    MODE_STRING  = 3'd6
  } lex_mode_t;

  localparam logic [3:0] KIND_SPACE   = 4'd0;
  localparam logic [3:0] KIND_COMMENT = 4'd1;
  localparam logic [3:0] KIND_IDENT   = 4'd2;
  localparam logic [3:0] KIND_KEYWORD = 4'd3;
  localparam logic [3:0] KIND_NUMBER  = 4'd4;
  localparam logic [3:0] KIND_STRING  = 4'd5;
  localparam logic [3:0] KIND_OP      = 4'd6;
  localparam logic [3:0] KIND_END     = 4'd7;
  localparam logic [3:0] KIND_ERROR   = 4'd8;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN = 2'd3;

  localparam logic [4:0] OP_NONE = 5'd31;

  // One token record.
  typedef struct packed {
    logic [3:0]              kind;
    logic [4:0]              code;
    logic [OUT_LEN_BITS-1:0] length;
    logic [1:0]              error;
    logic                    last;
  } token_t;

  // Up to three records caused by one character.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } token_group_t;

  function automatic token_t make_token(logic [3:0] kind, logic [4:0] code,
                                        logic [LENGTH_BITS-1:0] len, logic [1:0] err);
    token_t t;
    t.kind = kind;
    t.code = code;
    t.length = (LENGTH_BITS > OUT_LEN_BITS && len > LENGTH_BITS'(16'hFFFF)) ?
               16'hFFFF : OUT_LEN_BITS'(len);
    t.error = err;
    t.last = 1'b0;
    return t;
  endfunction

  // Keyword character at position pos, zero past the end.
  function automatic logic [7:0] kw_char(int unsigned k, logic [2:0] pos);
    logic [63:0] s;
    case (k)
      0: s = {"if", 48'd0};
      1: s = {"then", 32'd0};
      2: s = {"else", 32'd0};
      3: s = {"while", 24'd0};
      4: s = {"loop", 32'd0};
      5: s = {"endloop", 8'd0};
      6: s = {"print", 24'd0};
      7: s = {"return", 16'd0};
      8: s = {"exit", 32'd0};
      default: s = 64'd0;
    endcase
    return s[63 - 8 * pos -: 8];
  endfunction

  function automatic logic [4:0] one_op(logic [7:0] c);
    case (c)
      "=": return 5'd0;
      "(": return 5'd1;
      ")": return 5'd2;
      "<": return 5'd3;
      ">": return 5'd4;
      "/": return 5'd5;
      "*": return 5'd6;
      "+": return 5'd7;
      "-": return 5'd8;
      "!": return 5'd9;
      "&": return 5'd10;
      ".": return 5'd11;
      ";": return 5'd12;
      "^": return 5'd18;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic logic [4:0] two_op(logic [7:0] a, logic [7:0] b);
    logic [4:0] r;
    r = OP_NONE;
    if (a == "=" && b == "=") r = 5'd13;
    if (a == "<" && b == "=") r = 5'd14;
    if (a == ">" && b == "=") r = 5'd15;
    if (a == "!" && b == "=") r = 5'd16;
    if (a == "+" && b == "+") r = 5'd17;
    if (a == "-" && b == "-") r = 5'd19;
    if (a == "+" && b == "=") r = 5'd20;
    if (a == "-" && b == "=") r = 5'd21;
    if (a == "|" && b == "|") r = 5'd22;
    return r;
  endfunction

endpackage

// ===== src/kot_front.sv =====
module kot_front
  import kot_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   char_code,
  input  logic         end_of_text,
  input  logic         take,
  output token_group_t group
);

  lex_mode_t              lex_mode, lex_mode_next;
  logic [7:0]             held_char, held_char_next;
  logic                   held_valid, held_valid_next;
  logic [LENGTH_BITS-1:0] run_length, run_length_next;
  logic [8:0]             cand, cand_next;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Character classes.
  logic c_space, c_letter, c_digit, c_ident, c_pair;
  assign c_space  = char_code == " " || char_code == 8'h0A || char_code == 8'h09 ||
                    char_code == 8'h0D;
  assign c_letter = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z");
  assign c_digit  = char_code >= "0" && char_code <= "9";
  assign c_ident  = c_letter || c_digit || char_code == "_";
  assign c_pair   = char_code == "=" || char_code == "<" || char_code == ">" ||
                    char_code == "!" || char_code == "+" || char_code == "-" ||
                    char_code == "|" || char_code == "/";

  logic [LENGTH_BITS-1:0] run_inc;
  assign run_inc = (run_length == LEN_MAX) ? run_length : run_length + 1'b1;

  // Keyword mask filtered by the current character at the current position.
  logic [8:0] cand_filt, cand_first, kw_end;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cand_filt[k] = cand[k] && run_length < 8 &&
                     kw_char(k, run_length[2:0]) == char_code;
      cand_first[k] = kw_char(k, 3'd0) == char_code;
      kw_end[k] = cand[k] && run_length < 8 && kw_char(k, run_length[2:0]) == 8'd0;
    end
  end

  // Highest keyword that ends here.
  logic       kw_hit;
  logic [4:0] kw_idx;
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 5'd0;
    for (int k = 0; k < 9; k++) begin
      if (kw_end[k]) begin
        kw_hit = 1'b1;
        kw_idx = 5'(k);
      end
    end
  end

  // Record that closes the open run, if any.
  logic   close_valid;
  token_t close_tok;
  always_comb begin
    close_valid = 1'b1;
    close_tok = make_token(KIND_SPACE, 5'd0, run_length, ERR_NONE);
    case (lex_mode)
      MODE_SPACE:  close_tok = make_token(KIND_SPACE, 5'd0, run_length, ERR_NONE);
      MODE_NUMBER: close_tok = make_token(KIND_NUMBER, 5'd0, run_length, ERR_NONE);
      MODE_IDENT:  close_tok = kw_hit ?
                     make_token(KIND_KEYWORD, kw_idx, run_length, ERR_NONE) :
                     make_token(KIND_IDENT, 5'd0, run_length, ERR_NONE);
      MODE_COMMENT, MODE_CSTAR:
        close_tok = make_token(KIND_ERROR, 5'd0, run_length, ERR_COMMENT);
      MODE_STRING: close_tok = make_token(KIND_ERROR, 5'd0, run_length, ERR_STRING);
      default:     close_valid = 1'b0;
    endcase
  end

  // Held character emitted on its own, as an operator or an unknown-character error.
  token_t held_tok;
  assign held_tok = (one_op(held_char) != OP_NONE) ?
                    make_token(KIND_OP, one_op(held_char), LENGTH_BITS'(1), ERR_NONE) :
                    make_token(KIND_ERROR, 5'd0, LENGTH_BITS'(1), ERR_UNKNOWN);

  logic [4:0] pair_idx, single_idx;
  assign pair_idx   = two_op(held_char, char_code);
  assign single_idx = one_op(char_code);

  // Next state and records for one item.
  token_t tl [3];
  logic [1:0] n;
  logic start;
  always_comb begin
    lex_mode_next = lex_mode;
    held_char_next = held_char;
    held_valid_next = held_valid;
    run_length_next = run_length;
    cand_next = cand;
    for (int i = 0; i < 3; i++) tl[i] = make_token(KIND_END, 5'd0, '0, ERR_NONE);
    n = 2'd0;
    start = 1'b0;
    if (end_of_text) begin
      if (lex_mode == MODE_IDLE) begin
        if (held_valid) begin
          tl[n] = held_tok;
          n = n + 2'd1;
        end
      end else if (close_valid) begin
        tl[n] = close_tok;
        n = n + 2'd1;
      end
      tl[n] = make_token(KIND_END, 5'd0, '0, ERR_NONE);
      n = n + 2'd1;
      lex_mode_next = MODE_IDLE;
      held_char_next = 8'd0;
      held_valid_next = 1'b0;
      run_length_next = '0;
      cand_next = '1;
    end else begin
      case (lex_mode)
        MODE_SPACE: begin
          if (c_space) run_length_next = run_inc;
          else start = 1'b1;
        end
        MODE_NUMBER: begin
          if (c_digit) run_length_next = run_inc;
          else start = 1'b1;
        end
        MODE_IDENT: begin
          if (c_ident) begin
            cand_next = cand_filt;
            run_length_next = run_inc;
          end else begin
            start = 1'b1;
          end
        end
        MODE_STRING: begin
          run_length_next = run_inc;
          if (char_code == 8'h22) begin
            tl[0] = make_token(KIND_STRING, 5'd0, run_inc, ERR_NONE);
            n = 2'd1;
            lex_mode_next = MODE_IDLE;
            run_length_next = '0;
          end
        end
        MODE_COMMENT: begin
          run_length_next = run_inc;
          if (char_code == "*") lex_mode_next = MODE_CSTAR;
        end
        MODE_CSTAR: begin
          run_length_next = run_inc;
          if (char_code == "/") begin
            tl[0] = make_token(KIND_COMMENT, 5'd0, run_inc, ERR_NONE);
            n = 2'd1;
            lex_mode_next = MODE_IDLE;
            run_length_next = '0;
          end else if (char_code != "*") begin
            lex_mode_next = MODE_COMMENT;
          end
        end
        default: begin
          if (held_valid && held_char == "/" && char_code == "*") begin
            held_valid_next = 1'b0;
            held_char_next = 8'd0;
            lex_mode_next = MODE_COMMENT;
            run_length_next = LENGTH_BITS'(2);
          end else if (held_valid && pair_idx != OP_NONE) begin
            tl[0] = make_token(KIND_OP, pair_idx, LENGTH_BITS'(2), ERR_NONE);
            n = 2'd1;
            held_valid_next = 1'b0;
            held_char_next = 8'd0;
          end else begin
            if (held_valid) begin
              tl[0] = held_tok;
              n = 2'd1;
              held_valid_next = 1'b0;
              held_char_next = 8'd0;
            end
            start = 1'b1;
          end
        end
      endcase
      // Start a new token from this character.
      if (start) begin
        if (lex_mode != MODE_IDLE && close_valid) begin
          tl[n] = close_tok;
          n = n + 2'd1;
        end
        lex_mode_next = MODE_IDLE;
        run_length_next = LENGTH_BITS'(1);
        cand_next = '1;
        if (c_space) lex_mode_next = MODE_SPACE;
        else if (c_letter) begin
          lex_mode_next = MODE_IDENT;
          cand_next = cand_first;
        end else if (c_digit) lex_mode_next = MODE_NUMBER;
        else if (char_code == 8'h22) lex_mode_next = MODE_STRING;
        else begin
          run_length_next = '0;
          if (c_pair) begin
            held_char_next = char_code;
            held_valid_next = 1'b1;
          end else begin
            tl[n] = (single_idx != OP_NONE) ?
                    make_token(KIND_OP, single_idx, LENGTH_BITS'(1), ERR_NONE) :
                    make_token(KIND_ERROR, 5'd0, LENGTH_BITS'(1), ERR_UNKNOWN);
            n = n + 2'd1;
          end
        end
      end
    end
    group.count = n;
    group.t0 = tl[0];
    group.t1 = tl[1];
    group.t2 = tl[2];
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= MODE_IDLE;
      held_char <= 8'd0;
      held_valid <= 1'b0;
      run_length <= '0;
      cand <= '1;
    end else if (take) begin
      lex_mode <= lex_mode_next;
      held_char <= held_char_next;
      held_valid <= held_valid_next;
      run_length <= run_length_next;
      cand <= cand_next;
    end
  end

endmodule

// ===== src/kot_queue.sv =====
module kot_queue
  import kot_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  token_group_t push_group,
  output logic         has_room,
  output logic         head_valid,
  output token_group_t head_group,
  input  logic         pop
);

  token_group_t mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;

  assign has_room   = fill < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 1);
  assign head_valid = fill != '0;
  assign head_group = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_group;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
    end
  end

endmodule

// ===== src/kot_back.sv =====
module kot_back
  import kot_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  token_group_t head_group,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output token_t       out_token
);

  logic [1:0] idx;
  token_t     sel;
  logic       free, group_done;

  // Pick the next record of the head group.
  always_comb begin
    case (idx)
      2'd0:    sel = head_group.t0;
      2'd1:    sel = head_group.t1;
      default: sel = head_group.t2;
    endcase
    sel.last = (idx + 2'd1) == head_group.count;
  end

  assign free       = !out_valid || !out_stall;
  assign group_done = head_valid && free &&
                      (head_group.count == 2'd0 || sel.last);
  assign pop        = group_done;

  // Output register and record index.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else if (free) begin
      out_valid <= head_valid && head_group.count != 2'd0;
      if (group_done) idx <= 2'd0;
      else if (head_valid) idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (free) out_token <= sel;
  end

endmodule

// ===== src/keyword_operator_tokenizer_core.sv =====
// Channel   Direction  Handshake       Payload
// input     in         valid / stall   char_code, end_of_text
// output    out        out_valid/out_stall  token_kind, token_code, token_length,
//                                      error_code, last_result
// One character is accepted per cycle while the record queue has room; the
// lexer state registers update on each accepted character. Each character
// yields zero to two records, which leave at one record per cycle while
// out_stall is low, so a burst of multi-record characters fills the queue
// and raises stall. Reset clears the lexer state and empties the queue.
module keyword_operator_tokenizer_core
  import kot_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    stall,
  input  logic [7:0]              char_code,
  input  logic                    end_of_text,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              token_kind,
  output logic [4:0]              token_code,
  output logic [OUT_LEN_BITS-1:0] token_length,
  output logic [1:0]              error_code,
  output logic                    last_result
);

  token_group_t grp, head_group;
  logic has_room, head_valid, pop, take;
  token_t tok;

  assign stall = !has_room;
  assign take  = valid && has_room;

  kot_front u_front (
    .clk(clk), .rst(rst), .char_code(char_code), .end_of_text(end_of_text),
    .take(take), .group(grp)
  );

  kot_queue u_queue (
    .clk(clk), .rst(rst), .push(take && grp.count != 2'd0), .push_group(grp),
    .has_room(has_room), .head_valid(head_valid), .head_group(head_group), .pop(pop)
  );

  kot_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_group(head_group),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_token(tok)
  );

  assign token_kind   = tok.kind;
  assign token_code   = tok.code;
  assign token_length = tok.length;
  assign error_code   = tok.error;
  assign last_result  = tok.last;

endmodule

// ===== src/kot_checker.sv =====
module kot_checker
  import kot_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] token_kind,
  input logic [4:0] token_code,
  input logic [1:0] error_code,
  input logic       last_result
);

  // An end record is always the last of its request.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |-> last_result)
    else $error("end record not last");

  // Only error records carry an error code.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> token_kind == KIND_ERROR)
    else $error("error code on non-error record");

  // Codes appear only on keywords and operators.
  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_code != 5'd0 |-> token_kind == KIND_KEYWORD ||
    token_kind == KIND_OP)
    else $error("code on wrong kind");

  // A stalled record holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind))
    else $error("stalled record changed");

endmodule

bind keyword_operator_tokenizer_core kot_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .token_kind(token_kind), .token_code(token_code), .error_code(error_code),
  .last_result(last_result)
);
